>>> hdl/wrt_pkg.sv
// Shared constants, codes and record types of the waypoint route tracker.
package wrt_pkg;

   localparam int MAX_WAYPOINTS = 256;
   localparam int COORD_BITS    = 24;
   localparam int ADDR_BITS     = $clog2(MAX_WAYPOINTS);
   localparam int COUNT_BITS    = ADDR_BITS + 1;
   localparam int MAG_BITS      = COORD_BITS + 1;
   localparam int SUM_BITS      = 2 * MAG_BITS;
   localparam int ROOT_BITS     = MAG_BITS;
   localparam int REM_BITS      = ROOT_BITS + 3;
   localparam int ITER_BITS     = $clog2(ROOT_BITS + 1);
   localparam int LEN_BITS      = 40;
   localparam int TOL_BITS      = 16;
   localparam int ID_BITS       = 16;
   localparam int SPEED_BITS    = 16;
   localparam int OP_BITS       = 2;

   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REPORT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd2560;

   typedef struct packed {
      logic [ID_BITS-1:0]           id;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [SPEED_BITS-1:0]        speed;
   } wp_type;

   typedef struct packed {
      logic                  reached;
      logic                  next_valid;
      wp_type                wp;
      logic [COUNT_BITS-1:0] target_index;
      logic [COUNT_BITS-1:0] route_count;
      logic [LEN_BITS-1:0]   path_length;
      logic                  status;
   } rsp_type;

endpackage

>>> hdl/waypoint_route_tracker.sv
// Waypoint route tracker: waypoint table, target pointer and path length.
// A clear, an unused code, a dropped append or a report with no target only fetches and
// loads the result; the first append of a route writes first; other reports and appends
// read the table and make four passes of the shared multiplier, and appends then run the
// square root unit. One item at a time; the next item is taken once the result has been
// registered. Synchronous reset empties the route and restores the tolerance.
module waypoint_route_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [wrt_pkg::TOL_BITS-1:0]           csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [wrt_pkg::OP_BITS-1:0]            req_operation,
   input  logic [wrt_pkg::ID_BITS-1:0]            req_wp_id,
   input  logic signed [wrt_pkg::COORD_BITS-1:0]  req_x_coord,
   input  logic signed [wrt_pkg::COORD_BITS-1:0]  req_y_coord,
   input  logic signed [wrt_pkg::COORD_BITS-1:0]  req_z_coord,
   input  logic [wrt_pkg::SPEED_BITS-1:0]         req_wp_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_reached,
   output logic                                   rsp_next_valid,
   output logic [wrt_pkg::ID_BITS-1:0]            rsp_next_id,
   output logic signed [wrt_pkg::COORD_BITS-1:0]  rsp_next_x,
   output logic signed [wrt_pkg::COORD_BITS-1:0]  rsp_next_y,
   output logic signed [wrt_pkg::COORD_BITS-1:0]  rsp_next_z,
   output logic [wrt_pkg::SPEED_BITS-1:0]         rsp_next_speed,
   output logic [wrt_pkg::COUNT_BITS-1:0]         rsp_target_index,
   output logic [wrt_pkg::COUNT_BITS-1:0]         rsp_route_count,
   output logic [wrt_pkg::LEN_BITS-1:0]           rsp_path_length,
   output logic                                   rsp_status
);
   import wrt_pkg::*;

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RD     = 4'd1;
   localparam logic [3:0] ST_SQX    = 4'd2;
   localparam logic [3:0] ST_SQY    = 4'd3;
   localparam logic [3:0] ST_SQZ    = 4'd4;
   localparam logic [3:0] ST_SQT    = 4'd5;
   localparam logic [3:0] ST_DECIDE = 4'd6;
   localparam logic [3:0] ST_SQRT   = 4'd7;
   localparam logic [3:0] ST_ACCUM  = 4'd8;
   localparam logic [3:0] ST_WRITE  = 4'd9;
   localparam logic [3:0] ST_FETCH  = 4'd10;
   localparam logic [3:0] ST_LOAD   = 4'd11;

   // Magnitude of the difference of two signed coordinates; one bit wider than a coordinate.
   function automatic logic [MAG_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
      logic [MAG_BITS-1:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return d[MAG_BITS-1] ? (~d + 1'b1) : d;
   endfunction

   // control state
   logic [3:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic [LEN_BITS-1:0]   length_ff, length_in;
   logic [TOL_BITS-1:0]   tol_ff, tol_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   logic [OP_BITS-1:0]    op_ff, op_in;
   wp_type                item_ff, item_in;
   logic                  reached_ff, reached_in;
   logic                  status_ff, status_in;
   logic [SUM_BITS-1:0]   acc_ff, acc_in;
   logic [SUM_BITS-1:0]   prod_ff, prod_in;
   rsp_type               rsp_ff, rsp_in;

   // waypoint table
   wp_type                mem [MAX_WAYPOINTS];
   wp_type                rd_data_ff;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [ADDR_BITS-1:0]  mem_rd_addr;

   // shared multiplier and square root unit
   logic [MAG_BITS-1:0]   mag_op;
   logic                  sqrt_start;
   logic                  sqrt_busy;
   logic [ROOT_BITS-1:0]  sqrt_root;
   logic [LEN_BITS:0]     len_sum;
   logic                  slot_free;
   logic                  has_target;

   wrt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   // Feed the multiplier: one axis difference per pass, then the tolerance.
   always_comb begin
      case (state_ff)
         ST_SQX:  mag_op = abs_diff(item_ff.x, rd_data_ff.x);
         ST_SQY:  mag_op = abs_diff(item_ff.y, rd_data_ff.y);
         ST_SQZ:  mag_op = abs_diff(item_ff.z, rd_data_ff.z);
         ST_SQT:  mag_op = MAG_BITS'(tol_ff);
         default: mag_op = '0;
      endcase
   end

   assign prod_in    = mag_op * mag_op;
   assign len_sum    = {1'b0, length_ff} + (LEN_BITS + 1)'(sqrt_root);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign has_target = (target_ff < count_ff);
   assign tol_in     = csr_wr_en ? csr_wr_data : tol_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      length_in    = length_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      reached_in   = reached_ff;
      status_in    = status_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sqrt_start   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = target_ff[ADDR_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // capture the item and pick its path
               op_in      = req_operation;
               item_in    = '{id: req_wp_id, x: req_x_coord, y: req_y_coord,
                              z: req_z_coord, speed: req_wp_speed};
               reached_in = 1'b0;
               status_in  = STATUS_OK;
               state_in   = ST_FETCH;
               unique case (req_operation)
                  OP_APPEND: begin
                     if (count_ff == COUNT_BITS'(MAX_WAYPOINTS)) begin
                        status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_WRITE;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  OP_REPORT: begin
                     if (has_target) begin
                        state_in = ST_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     target_in = '0;
                     length_in = '0;
                  end
                  default: begin
                     state_in = ST_FETCH;
                  end
               endcase
            end
         end
         ST_RD: begin
            // previous waypoint for an append, current target for a report
            mem_rd_en   = 1'b1;
            mem_rd_addr = (op_ff == OP_APPEND) ? ADDR_BITS'(count_ff - 1'b1)
                                               : target_ff[ADDR_BITS-1:0];
            state_in    = ST_SQX;
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = prod_ff;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_SQT;
         end
         ST_SQT: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // prod now holds the squared tolerance
            if (op_ff == OP_APPEND) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               if (acc_ff < prod_ff) begin
                  target_in  = target_ff + 1'b1;
                  reached_in = 1'b1;
               end
               state_in = ST_FETCH;
            end
         end
         ST_SQRT: begin
            if (!sqrt_busy) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            // saturate the path length at all ones
            length_in = len_sum[LEN_BITS] ? '1 : len_sum[LEN_BITS-1:0];
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            mem_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_in.reached      = reached_ff;
               rsp_in.next_valid   = has_target;
               rsp_in.wp           = has_target ? rd_data_ff : '0;
               rsp_in.target_index = target_ff;
               rsp_in.route_count  = count_ff;
               rsp_in.path_length  = length_ff;
               rsp_in.status       = status_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         length_ff    <= '0;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         length_ff    <= length_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      item_ff    <= item_in;
      reached_ff <= reached_in;
      status_ff  <= status_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   // table: one write port at the fill point, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[count_ff[ADDR_BITS-1:0]] <= item_ff;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reached      = rsp_ff.reached;
   assign rsp_next_valid   = rsp_ff.next_valid;
   assign rsp_next_id      = rsp_ff.wp.id;
   assign rsp_next_x       = rsp_ff.wp.x;
   assign rsp_next_y       = rsp_ff.wp.y;
   assign rsp_next_z       = rsp_ff.wp.z;
   assign rsp_next_speed   = rsp_ff.wp.speed;
   assign rsp_target_index = rsp_ff.target_index;
   assign rsp_route_count  = rsp_ff.route_count;
   assign rsp_path_length  = rsp_ff.path_length;
   assign rsp_status       = rsp_ff.status;

   // The pointer never runs past the fill point.
   a_target_in_range: assert property (@(posedge clock) disable iff (reset)
      target_ff <= count_ff)
      else $error("target pointer beyond route count");

   // A reported target lies inside the route.
   a_next_in_route: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_next_valid) |-> (rsp_target_index < rsp_route_count))
      else $error("next waypoint reported outside the route");

   // With no target left the waypoint fields read zero.
   a_empty_next_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_next_valid) |->
         (rsp_next_id == '0 && rsp_next_x == '0 && rsp_next_y == '0 &&
          rsp_next_z == '0 && rsp_next_speed == '0))
      else $error("stale waypoint on an empty target");

   // Reached and table full never come from the same item.
   a_reached_excl_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reached && rsp_status))
      else $error("reached and full status together");

   // The root unit only runs while the sequencer waits on it.
   a_sqrt_owned: assert property (@(posedge clock) disable iff (reset)
      sqrt_busy |-> (state_ff == ST_SQRT))
      else $error("square root unit busy outside its wait state");

endmodule

>>> hdl/wrt_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module wrt_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wrt_pkg::SUM_BITS-1:0]  radicand,
   output logic                          busy,
   output logic [wrt_pkg::ROOT_BITS-1:0] root
);
   import wrt_pkg::*;

   logic [SUM_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [ITER_BITS-1:0] cnt_ff, cnt_in;
   logic [REM_BITS-1:0]  rem_sh;
   logic [REM_BITS-1:0]  trial;
   logic                 fits;

   assign rem_sh = {rem_ff[REM_BITS-3:0], rad_ff[SUM_BITS-1 -: 2]};
   assign trial  = REM_BITS'({root_ff, 2'b01});
   assign fits   = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = ITER_BITS'(ROOT_BITS);
      end else if (cnt_ff != '0) begin
         // retire one root bit
         rad_in  = {rad_ff[SUM_BITS-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule
